>>> hdl/rmth_pkg.sv
package rmth_pkg;

  localparam int HEAP_DEPTH = 512;
  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = AW + 1;
  localparam int DW = 32;
  localparam int NW = 10;
  localparam int TOTAL_MAX = 2 * HEAP_DEPTH - 1;

  // controller step codes, also decoded by the datapath
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_PU_RD   = 4'd1;
  localparam logic [3:0] ST_PU_CMP  = 4'd2;
  localparam logic [3:0] ST_BAL     = 4'd3;
  localparam logic [3:0] ST_PO_LAST = 4'd4;
  localparam logic [3:0] ST_PO_RD1  = 4'd5;
  localparam logic [3:0] ST_PO_RD2  = 4'd6;
  localparam logic [3:0] ST_PO_CMP  = 4'd7;
  localparam logic [3:0] ST_DONE    = 4'd8;

  typedef struct packed {
    logic [3:0] step;
    logic       sel;       // heap worked on by this step, 1 = lower
    logic       push_sel;  // heap that push_init targets
    logic       accept;
    logic       push_init;
    logic       src_mv;
    logic       pop_init;
    logic       load_out;
  } rmth_cmd_t;

  typedef struct packed {
    logic full;
    logic to_lower;
    logic at_root;
    logic up_more;
    logic no_left;
    logic down_swap;
    logic bal_u2l;
    logic bal_l2u;
    logic out_free;
  } rmth_status_t;

  // true when a sits above b in the heap
  function automatic logic ranks_above(input logic signed [DW-1:0] a,
                                       input logic signed [DW-1:0] b,
                                       input logic is_max);
    ranks_above = is_max ? (a > b) : (a < b);
  endfunction

endpackage

>>> hdl/running_median_two_heaps_unit.sv
// Running median of a stream of signed 32-bit samples, kept as a max-heap of
// the lower half and a min-heap of the upper half, each in a 512-entry memory
// with one write port and one registered read port. One transaction in gives
// one transaction out: the median after the sample (lower median on an even
// count), the number of samples held, and a drop flag once 1023 samples are
// held. Items are handled one at a time: an insert walks up its heap with a read
// and a compare step per level, and when a rebalance is needed the pop walks
// down the fuller heap, the one just pushed, with two reads and a compare per
// level, as each heap memory has one read port, and re-inserts its top into
// the other heap; a dropped item skips the heap walks. A result that waits for
// m_tready holds back the next ready. The heap memories need no clearing after
// reset.
module running_median_two_heaps_unit import rmth_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // sample_value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // median_value, item_count, zero pad
  output logic        m_tuser    // dropped
);

  rmth_cmd_t    cmd;
  rmth_status_t status;

  // sequencer
  rmth_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // heaps, walk registers and result register
  rmth_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // a dropped sample reports a full store
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[41:32] == NW'(TOTAL_MAX)))
    else $error("dropped result without full count");

  // one sample at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("ready right after a transaction");

  // a result only appears after a load
  a_load: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.load_out))
    else $error("result without load");

endmodule

>>> hdl/rmth_ctrl.sv
module rmth_ctrl import rmth_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  rmth_status_t status,
  output rmth_cmd_t    cmd
);

  logic [3:0] state, state_next;
  logic       sel, sel_next;
  logic       phase, phase_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sel   <= 1'b0;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
      phase <= phase_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  // sequencing of insert, rebalance pop and rebalance push
  always_comb begin
    state_next    = state;
    sel_next      = sel;
    phase_next    = phase;
    cmd           = '0;
    cmd.step      = state;
    cmd.sel       = sel;
    cmd.push_sel  = sel;
    case (state)
      ST_IDLE: begin
        cmd.push_sel = status.to_lower;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          if (status.full) begin
            state_next = ST_DONE;
          end else begin
            cmd.push_init = 1'b1;
            sel_next      = status.to_lower;
            phase_next    = 1'b0;
            state_next    = ST_PU_RD;
          end
        end
      end
      ST_PU_RD: begin
        if (status.at_root) begin
          state_next = phase ? ST_DONE : ST_BAL;
        end else begin
          state_next = ST_PU_CMP;
        end
      end
      ST_PU_CMP: begin
        if (status.up_more) begin
          state_next = ST_PU_RD;
        end else begin
          state_next = phase ? ST_DONE : ST_BAL;
        end
      end
      ST_BAL: begin
        cmd.sel = status.bal_l2u;
        if (status.bal_u2l || status.bal_l2u) begin
          cmd.pop_init = 1'b1;
          sel_next     = status.bal_l2u;
          state_next   = ST_PO_LAST;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_PO_LAST: begin
        state_next = ST_PO_RD1;
      end
      ST_PO_RD1: begin
        cmd.push_sel = ~sel;
        if (status.no_left) begin
          cmd.push_init = 1'b1;
          cmd.src_mv    = 1'b1;
          sel_next      = ~sel;
          phase_next    = 1'b1;
          state_next    = ST_PU_RD;
        end else begin
          state_next = ST_PO_RD2;
        end
      end
      ST_PO_RD2: begin
        state_next = ST_PO_CMP;
      end
      ST_PO_CMP: begin
        cmd.push_sel = ~sel;
        if (status.down_swap) begin
          state_next = ST_PO_RD1;
        end else begin
          cmd.push_init = 1'b1;
          cmd.src_mv    = 1'b1;
          sel_next      = ~sel;
          phase_next    = 1'b1;
          state_next    = ST_PU_RD;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/rmth_dpath.sv
module rmth_dpath import rmth_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  rmth_cmd_t            cmd,
  output rmth_status_t         status,
  input  logic signed [DW-1:0] s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [47:0]          m_tdata,
  output logic                 m_tuser
);

  logic signed [DW-1:0] mem_u [HEAP_DEPTH];
  logic signed [DW-1:0] mem_l [HEAP_DEPTH];
  logic signed [DW-1:0] rd_u, rd_l, rdata;
  logic [CW-1:0]        cnt_u, cnt_l, cnt_sel, cnt_push;
  logic signed [DW-1:0] top_u, top_l, top_sel;
  logic [AW-1:0]        idx, bidx;
  logic signed [DW-1:0] cur, mv, best_val;
  logic                 drop;
  logic                 we;
  logic [AW-1:0]        wa, ra;
  logic signed [DW-1:0] wd;
  logic [AW-1:0]        parent;
  logic [CW:0]          lft, rgt;
  logic                 right_ok, take_right;
  logic signed [DW-1:0] choose;
  logic [AW-1:0]        choose_idx;
  logic [CW:0]          total;
  logic signed [DW-1:0] median;

  assign rdata    = cmd.sel ? rd_l : rd_u;
  assign cnt_sel  = cmd.sel ? cnt_l : cnt_u;
  assign cnt_push = cmd.push_sel ? cnt_l : cnt_u;
  assign top_sel  = cmd.sel ? top_l : top_u;
  assign parent   = (idx - 1'b1) >> 1;
  assign lft      = {{1'b0, idx}, 1'b1};
  assign rgt      = lft + 1'b1;
  assign right_ok = rgt < {1'b0, cnt_sel};
  assign take_right = right_ok && ranks_above(rdata, best_val, cmd.sel);
  assign choose     = take_right ? rdata : best_val;
  assign choose_idx = take_right ? rgt[AW-1:0] : bidx;
  assign total      = {1'b0, cnt_u} + {1'b0, cnt_l};

  // status toward the controller
  always_comb begin
    status.full      = total >= (CW+1)'(TOTAL_MAX);
    status.to_lower  = !((cnt_u != '0) && (s_tdata > top_u)) &&
                       ((cnt_l != '0) && (s_tdata < top_l));
    status.at_root   = idx == '0;
    status.up_more   = ranks_above(cur, rdata, cmd.sel);
    status.no_left   = lft >= {1'b0, cnt_sel};
    status.down_swap = ranks_above(choose, cur, cmd.sel);
    status.bal_u2l   = cnt_u > cnt_l + 1'b1;
    status.bal_l2u   = cnt_l > cnt_u + 1'b1;
    status.out_free  = !m_tvalid || m_tready;
  end

  // memory port control per step
  always_comb begin
    we = 1'b0;
    wa = idx;
    wd = cur;
    ra = parent;
    case (cmd.step)
      ST_PU_RD: begin
        we = status.at_root;
      end
      ST_PU_CMP: begin
        we = 1'b1;
        wd = status.up_more ? rdata : cur;
      end
      ST_BAL: begin
        ra = AW'(cnt_sel - 1'b1);
      end
      ST_PO_RD1: begin
        we = status.no_left;
        ra = lft[AW-1:0];
      end
      ST_PO_RD2: begin
        ra = rgt[AW-1:0];
      end
      ST_PO_CMP: begin
        we = 1'b1;
        wd = status.down_swap ? choose : cur;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // upper heap memory
  always_ff @(posedge clk) begin
    if (we && !cmd.sel) begin
      mem_u[wa] <= wd;
    end
    rd_u <= mem_u[ra];
  end

  // lower heap memory
  always_ff @(posedge clk) begin
    if (we && cmd.sel) begin
      mem_l[wa] <= wd;
    end
    rd_l <= mem_l[ra];
  end

  // heap sizes
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_u <= '0;
      cnt_l <= '0;
    end else if (cmd.push_init) begin
      if (cmd.push_sel) cnt_l <= cnt_l + 1'b1;
      else              cnt_u <= cnt_u + 1'b1;
    end else if (cmd.pop_init) begin
      if (cmd.sel) cnt_l <= cnt_l - 1'b1;
      else         cnt_u <= cnt_u - 1'b1;
    end
  end

  // cached heap tops, follow every root write
  always_ff @(posedge clk) begin
    if (we && (wa == '0)) begin
      if (cmd.sel) top_l <= wd;
      else         top_u <= wd;
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      drop <= status.full;
    end
    if (cmd.push_init) begin
      idx <= cnt_push[AW-1:0];
      cur <= cmd.src_mv ? mv : s_tdata;
    end
    if (cmd.pop_init) begin
      mv <= top_sel;
    end
    case (cmd.step)
      ST_PU_CMP: if (status.up_more) idx <= parent;
      ST_PO_LAST: begin
        cur <= rdata;
        idx <= '0;
      end
      ST_PO_RD2: begin
        best_val <= rdata;
        bidx     <= lft[AW-1:0];
      end
      ST_PO_CMP: if (status.down_swap) idx <= choose_idx;
      default: ;
    endcase
  end

  // result register
  assign median = (cnt_u > cnt_l) ? top_u : ((cnt_l == '0) ? '0 : top_l);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {6'b0, total[NW-1:0], median};
      m_tuser <= drop;
    end
  end

endmodule
